FILE: hw/rtl/elliptic_curve_subgroup_generator_defines.svh
// Assertion macros for the elliptic curve subgroup generator
`ifndef ELLIPTIC_CURVE_SUBGROUP_GENERATOR_DEFINES_SVH
`define ELLIPTIC_CURVE_SUBGROUP_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ECSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ECSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ECSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ecsg_pkg.sv
// Shared constants and types of the subgroup generator
`default_nettype none
package ecsg_pkg;
    localparam int FIELD_BITS = 16;
    localparam int MAX_POINTS = 64;
    localparam int IDX_BITS   = 7;
    localparam int ADDR_BITS  = 3;
    localparam logic [ADDR_BITS-1:0] ADDR_PRIME = 3'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_COEFF = 3'd4;
    localparam logic [FIELD_BITS-1:0] PRIME_RESET = 16'd19;
    localparam logic [FIELD_BITS-1:0] COEFF_RESET = 16'd2;

    typedef logic [FIELD_BITS-1:0] t_elem;

    typedef struct packed {
        logic  start;
        t_elem op_a;
        t_elem op_b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_elem prod;
    } t_mul_rsp;
endpackage
`default_nettype wire

FILE: hw/rtl/ecsg_if.sv
// Valid/ready channel interfaces for input requests and result points
`default_nettype none
interface ecsg_in_if;
    logic                 valid;
    logic                 ready;
    ecsg_pkg::t_elem      gen_x;
    ecsg_pkg::t_elem      gen_y;
    modport source (output valid, gen_x, gen_y, input ready);
    modport sink (input valid, gen_x, gen_y, output ready);
endinterface

interface ecsg_out_if;
    logic                          valid;
    logic                          ready;
    ecsg_pkg::t_elem               point_x;
    ecsg_pkg::t_elem               point_y;
    logic [ecsg_pkg::IDX_BITS-1:0] multiple_index;
    logic                          last_point;
    logic                          run_status;
    modport source (output valid, point_x, point_y, multiple_index, last_point,
        run_status, input ready);
    modport sink (input valid, point_x, point_y, multiple_index, last_point,
        run_status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/elliptic_curve_subgroup_generator.sv
// Top level of the elliptic curve subgroup generator
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid/ready    | gen_x, gen_y
//  out_ch  | out | valid/ready    | point_x, point_y, multiple_index, last_point, run_status
//  apb     | in  | psel/penable   | field_prime @0x0, curve_coeff_a @0x4
// Input reduction runs x, y and a through the multiplier: three multiplies.
// The inverse takes one square per bit of p-2 and one multiply per set bit; a point adds
// the slope, square and y multiplies, and a request yields up to MAX_POINTS points.
// Reset is synchronous active low.
// A stalled result holds the sequencer; no new request is taken until the run ends.
`default_nettype none
module elliptic_curve_subgroup_generator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    ecsg_in_if.sink                          in_ch,
    ecsg_out_if.source                       out_ch,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [ecsg_pkg::ADDR_BITS-1:0]    paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    ecsg_pkg::t_elem r_prime, r_coeff, prime_use;
    ecsg_pkg::t_mul_req mreq;
    ecsg_pkg::t_mul_rsp mrsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= ecsg_pkg::PRIME_RESET;
            r_coeff <= ecsg_pkg::COEFF_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == ecsg_pkg::ADDR_PRIME) r_prime <= pwdata[ecsg_pkg::FIELD_BITS-1:0];
            if (paddr == ecsg_pkg::ADDR_COEFF) r_coeff <= pwdata[ecsg_pkg::FIELD_BITS-1:0];
        end
    end

    always_comb begin
        if (paddr == ecsg_pkg::ADDR_PRIME) prdata = {16'd0, r_prime};
        else if (paddr == ecsg_pkg::ADDR_COEFF) prdata = {16'd0, r_coeff};
        else prdata = '0;
    end
    assign pready = 1'b1;

    ecsg_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prime_raw(r_prime), .i_coeff(r_coeff),
        .in_ch(in_ch), .out_ch(out_ch), .o_prime(prime_use), .o_mreq(mreq), .i_mrsp(mrsp)
    );

    ecsg_modmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prime(prime_use), .i_req(mreq), .o_rsp(mrsp)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/ecsg_modmul.sv
// Shift-add modular multiplier, one bit of the multiplier per cycle
`default_nettype none
`include "elliptic_curve_subgroup_generator_defines.svh"
module ecsg_modmul (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ecsg_pkg::t_elem     i_prime,
    input  ecsg_pkg::t_mul_req  i_req,
    output ecsg_pkg::t_mul_rsp  o_rsp
);
    localparam int CNT_BITS = $clog2(ecsg_pkg::FIELD_BITS + 1);

    logic                  r_busy, n_busy;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    ecsg_pkg::t_elem       r_acc, n_acc;
    ecsg_pkg::t_elem       r_mcand, n_mcand;
    ecsg_pkg::t_elem       r_mplier, n_mplier;
    logic                  r_done, n_done;
    logic [ecsg_pkg::FIELD_BITS+1:0] dbl, dsub, add, asub;
    ecsg_pkg::t_elem       acc2;

    always_comb begin
        dbl  = {2'b0, r_acc} << 1;
        dsub = dbl - {2'b0, i_prime};
        acc2 = dsub[ecsg_pkg::FIELD_BITS+1] ? r_acc << 1 : dsub[ecsg_pkg::FIELD_BITS-1:0];
        add  = {2'b0, acc2} + {2'b0, r_mcand};
        asub = add - {2'b0, i_prime};
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_mcand = r_mcand;
        n_mplier = r_mplier;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt = CNT_BITS'(ecsg_pkg::FIELD_BITS);
            n_acc = '0;
            n_mcand = i_req.op_a;
            n_mplier = i_req.op_b;
        end else if (r_busy) begin
            if (r_mplier[ecsg_pkg::FIELD_BITS-1])
                n_acc = asub[ecsg_pkg::FIELD_BITS+1] ? add[ecsg_pkg::FIELD_BITS-1:0]
                                                     : asub[ecsg_pkg::FIELD_BITS-1:0];
            else
                n_acc = acc2;
            n_mplier = r_mplier << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_mcand <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    `ECSG_ASSERT_NEXT(a_done_ends_busy, i_clk, i_rst_n, n_done, !r_busy, "done while busy")
    `ECSG_ASSERT_IMPL(a_cnt_busy, i_clk, i_rst_n, r_busy, r_cnt != '0, "busy with zero count")
    `ECSG_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy, "start lost")
endmodule
`default_nettype wire

FILE: hw/rtl/ecsg_seq.sv
// Point sequencer: reduction, inverse, slope and coordinate steps
`default_nettype none
`include "elliptic_curve_subgroup_generator_defines.svh"
module ecsg_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ecsg_pkg::t_elem     i_prime_raw,
    input  ecsg_pkg::t_elem     i_coeff,
    ecsg_in_if.sink             in_ch,
    ecsg_out_if.source          out_ch,
    output ecsg_pkg::t_elem     o_prime,
    output ecsg_pkg::t_mul_req  o_mreq,
    input  ecsg_pkg::t_mul_rsp  i_mrsp
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_RED = 5'd1,  S_EMIT0 = 5'd2,
        S_D1 = 5'd3, S_D2 = 5'd4, S_RX = 5'd5, S_INV_SQ = 5'd6,
        S_INV_MUL = 5'd7, S_INV_CHK = 5'd8, S_SL = 5'd9, S_X1 = 5'd10,
        S_Y1 = 5'd11, S_EMIT = 5'd12, S_ADD0 = 5'd13, S_RY = 5'd14,
        S_RA = 5'd15;
    localparam int FB = ecsg_pkg::FIELD_BITS;

    logic [4:0] r_st, n_st, r_ret, n_ret;
    ecsg_pkg::t_elem r_p, n_p, r_a, n_a, r_x0, n_x0, r_y0, n_y0;
    ecsg_pkg::t_elem r_cx, n_cx, r_cy, n_cy, r_t, n_t;
    ecsg_pkg::t_elem r_base, n_base, r_rem, n_rem, r_res, n_res, r_s, n_s;
    logic [ecsg_pkg::IDX_BITS-1:0] r_k, n_k;
    logic r_last, n_last, r_trunc, n_trunc, r_dbl, n_dbl;
    logic r_wait, n_wait;
    ecsg_pkg::t_mul_req mreq;
    ecsg_pkg::t_elem pr;

    function automatic ecsg_pkg::t_elem msub(ecsg_pkg::t_elem u, ecsg_pkg::t_elem v,
                                             ecsg_pkg::t_elem m);
        logic [FB:0] d;
        d = {1'b0, u} - {1'b0, v};
        if (d[FB])
            d = d + {1'b0, m};
        return d[FB-1:0];
    endfunction

    function automatic ecsg_pkg::t_elem madd(ecsg_pkg::t_elem u, ecsg_pkg::t_elem v,
                                             ecsg_pkg::t_elem m);
        logic [FB:0] s, d;
        s = {1'b0, u} + {1'b0, v};
        d = s - {1'b0, m};
        return d[FB] ? s[FB-1:0] : d[FB-1:0];
    endfunction

    assign pr = (i_prime_raw < FB'(3)) ? FB'(3) : i_prime_raw;

    always_comb begin
        n_st = r_st; n_ret = r_ret; n_p = r_p; n_a = r_a; n_x0 = r_x0; n_y0 = r_y0;
        n_cx = r_cx; n_cy = r_cy; n_t = r_t; n_base = r_base; n_rem = r_rem;
        n_res = r_res; n_s = r_s; n_k = r_k; n_last = r_last; n_trunc = r_trunc;
        n_dbl = r_dbl; n_wait = r_wait;
        mreq = '0;
        if (r_wait) begin
            if (i_mrsp.done) begin
                n_wait = 1'b0;
                n_t = i_mrsp.prod;
                n_st = r_ret;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        n_p = pr; n_a = i_coeff;
                        n_x0 = in_ch.gen_x; n_y0 = in_ch.gen_y;
                        n_st = S_RED;
                    end
                end
                S_RED: begin
                    mreq = '{1'b1, FB'(1), r_x0};
                    n_wait = 1'b1; n_ret = S_RX;
                end
                S_RX: begin
                    n_x0 = r_t;
                    mreq = '{1'b1, FB'(1), r_y0};
                    n_wait = 1'b1; n_ret = S_RY;
                end
                S_RY: begin
                    n_y0 = r_t;
                    mreq = '{1'b1, FB'(1), r_a};
                    n_wait = 1'b1; n_ret = S_RA;
                end
                S_RA: begin
                    n_a = r_t;
                    n_cx = r_x0; n_cy = r_y0; n_k = ecsg_pkg::IDX_BITS'(1);
                    n_last = (r_y0 == '0); n_trunc = 1'b0;
                    n_st = S_EMIT0;
                end
                S_EMIT0: begin
                    if (out_ch.ready) begin
                        if (r_last) n_st = S_IDLE;
                        else begin
                            n_dbl = 1'b1;
                            mreq = '{1'b1, r_x0, r_x0};
                            n_wait = 1'b1; n_ret = S_D1;
                        end
                    end
                end
                S_D1: begin
                    n_s = madd(madd(madd(r_t, r_t, r_p), r_t, r_p), r_a, r_p);
                    n_base = madd(r_y0, r_y0, r_p);
                    n_st = S_D2;
                end
                S_D2: begin
                    n_rem = r_p - FB'(2); n_res = FB'(1);
                    n_st = S_INV_CHK;
                end
                S_INV_CHK: begin
                    if (r_rem == '0) begin
                        mreq = '{1'b1, r_s, r_res};
                        n_wait = 1'b1; n_ret = S_SL;
                    end else if (r_rem[0]) begin
                        mreq = '{1'b1, r_res, r_base};
                        n_wait = 1'b1; n_ret = S_INV_MUL;
                    end else begin
                        mreq = '{1'b1, r_base, r_base};
                        n_wait = 1'b1; n_ret = S_INV_SQ;
                        n_rem = r_rem >> 1;
                    end
                end
                S_INV_MUL: begin
                    n_res = r_t;
                    mreq = '{1'b1, r_base, r_base};
                    n_wait = 1'b1; n_ret = S_INV_SQ;
                    n_rem = r_rem >> 1;
                end
                S_INV_SQ: begin
                    n_base = r_t;
                    n_st = S_INV_CHK;
                end
                S_SL: begin
                    n_s = r_t;
                    mreq = '{1'b1, r_t, r_t};
                    n_wait = 1'b1; n_ret = S_X1;
                end
                S_X1: begin
                    if (r_dbl)
                        n_t = msub(r_t, madd(r_x0, r_x0, r_p), r_p);
                    else
                        n_t = msub(msub(r_t, r_x0, r_p), r_cx, r_p);
                    n_cx = n_t;
                    mreq = '{1'b1, r_s, msub(r_x0, n_t, r_p)};
                    n_wait = 1'b1; n_ret = S_Y1;
                end
                S_Y1: begin
                    n_cy = msub(r_t, r_y0, r_p);
                    n_k = r_k + 1'b1;
                    n_last = (r_cx == r_x0) ||
                        (r_k + 1'b1 >= ecsg_pkg::IDX_BITS'(ecsg_pkg::MAX_POINTS));
                    n_trunc = (r_cx != r_x0);
                    n_st = S_EMIT;
                end
                S_EMIT: begin
                    if (out_ch.ready) begin
                        if (r_last) n_st = S_IDLE;
                        else n_st = S_ADD0;
                    end
                end
                S_ADD0: begin
                    n_dbl = 1'b0;
                    n_s = msub(r_cy, r_y0, r_p);
                    n_base = msub(r_cx, r_x0, r_p);
                    n_st = S_D2;
                end
                default: n_st = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_wait <= 1'b0;
            r_ret <= S_IDLE;
        end else begin
            r_st <= n_st;
            r_wait <= n_wait;
            r_ret <= n_ret;
        end
        r_p <= n_p; r_a <= n_a; r_x0 <= n_x0; r_y0 <= n_y0; r_cx <= n_cx; r_cy <= n_cy;
        r_t <= n_t; r_base <= n_base; r_rem <= n_rem; r_res <= n_res; r_s <= n_s;
        r_k <= n_k; r_last <= n_last; r_trunc <= n_trunc; r_dbl <= n_dbl;
    end

    assign in_ch.ready = (r_st == S_IDLE) && !r_wait;
    assign out_ch.valid = !r_wait && ((r_st == S_EMIT0) || (r_st == S_EMIT));
    assign out_ch.point_x = r_cx;
    assign out_ch.point_y = r_cy;
    assign out_ch.multiple_index = r_k;
    assign out_ch.last_point = r_last;
    assign out_ch.run_status = r_last && r_trunc;
    assign o_prime = r_p;
    assign o_mreq = mreq;

    `ECSG_ASSERT_IMPL(a_no_req_wait, i_clk, i_rst_n, r_wait, !mreq.start, "request while waiting")
    `ECSG_ASSERT_IMPL(a_k_range, i_clk, i_rst_n, out_ch.valid,
        (r_k != '0) && (r_k <= ecsg_pkg::IDX_BITS'(ecsg_pkg::MAX_POINTS)), "index out of range")
    `ECSG_ASSERT_IMPL(a_x_reduced, i_clk, i_rst_n, out_ch.valid, r_cx < r_p, "x not reduced")
endmodule
`default_nettype wire

FILE: bench/ecsg_checker.sv
// Checker: watches the channels, predicts the multiples of each generator and compares
`timescale 1ns / 100ps
`default_nettype none
module ecsg_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    ecsg_in_if                            in_mon,
    ecsg_out_if                           out_mon,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire                           pready,
    input  wire [ecsg_pkg::ADDR_BITS-1:0] paddr,
    input  wire [31:0]                    pwdata,
    output int                            o_fail_count,
    output int                            o_points_due
);
    localparam int DEPTH = 128;

    typedef struct packed {
        ecsg_pkg::t_elem                x;
        ecsg_pkg::t_elem                y;
        logic [ecsg_pkg::IDX_BITS-1:0]  idx;
        logic                           last;
        logic                           status;
    } t_point;

    t_point          points_due [DEPTH];
    int              due_wr;
    int              due_rd;
    ecsg_pkg::t_elem prime_reg;
    ecsg_pkg::t_elem coeff_reg;

    function automatic longint unsigned mulm(longint unsigned u, v, m);
        return (u * v) % m;
    endfunction

    function automatic longint unsigned subm(longint unsigned u, v, m);
        return (u + m - v) % m;
    endfunction

    function automatic longint unsigned fermat_inv(longint unsigned d, m);
        longint unsigned b, e, r;
        b = d % m;
        e = m - 2;
        r = 1 % m;
        while (e != 0) begin
            if (e[0]) r = mulm(r, b, m);
            e = e >> 1;
            b = mulm(b, b, m);
        end
        return r;
    endfunction

    function automatic t_point mk_point(longint unsigned x, y, int k, bit last, bit trunc);
        t_point pt;
        pt.x      = x[ecsg_pkg::FIELD_BITS-1:0];
        pt.y      = y[ecsg_pkg::FIELD_BITS-1:0];
        pt.idx    = k[ecsg_pkg::IDX_BITS-1:0];
        pt.last   = last;
        pt.status = last && trunc;
        return pt;
    endfunction

    task automatic queue_point(t_point pt);
        points_due[due_wr % DEPTH] = pt;
        due_wr = due_wr + 1;
    endtask

    task automatic predict_multiples(ecsg_pkg::t_elem gx, ecsg_pkg::t_elem gy);
        longint unsigned p, a, x0, y0, s, nx, ny, cx, cy;
        int k;
        bit done;
        p = prime_reg;
        if (p < 3) p = 3;
        a  = coeff_reg % p;
        x0 = gx % p;
        y0 = gy % p;
        if (y0 == 0) begin
            queue_point(mk_point(x0, y0, 1, 1, 0));
            return;
        end
        queue_point(mk_point(x0, y0, 1, 0, 0));
        k = 1;
        s  = (mulm(3, mulm(x0, x0, p), p) + a) % p;
        s  = mulm(s, fermat_inv(mulm(2, y0, p), p), p);
        nx = subm(mulm(s, s, p), mulm(2, x0, p), p);
        ny = subm(mulm(s, subm(x0, nx, p), p), y0, p);
        forever begin
            cx = nx;
            cy = ny;
            done = (nx == x0);
            if (done || k + 1 >= ecsg_pkg::MAX_POINTS) begin
                queue_point(mk_point(nx, ny, k + 1, 1, !done));
                break;
            end
            queue_point(mk_point(nx, ny, k + 1, 0, 0));
            k++;
            s  = mulm(subm(cy, y0, p), fermat_inv(subm(cx, x0, p), p), p);
            nx = subm(subm(mulm(s, s, p), x0, p), cx, p);
            ny = subm(mulm(s, subm(x0, nx, p), p), y0, p);
        end
    endtask

    always @(posedge i_clk) begin
        t_point want, got;
        if (!i_rst_n) begin
            prime_reg    = ecsg_pkg::PRIME_RESET;
            coeff_reg    = ecsg_pkg::COEFF_RESET;
            due_wr       = 0;
            due_rd       = 0;
            o_fail_count <= 0;
            o_points_due <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ecsg_pkg::ADDR_PRIME)
                    prime_reg = pwdata[ecsg_pkg::FIELD_BITS-1:0];
                else if (paddr == ecsg_pkg::ADDR_COEFF)
                    coeff_reg = pwdata[ecsg_pkg::FIELD_BITS-1:0];
            end
            if (in_mon.valid && in_mon.ready)
                predict_multiples(in_mon.gen_x, in_mon.gen_y);
            if (out_mon.valid && out_mon.ready) begin
                got.x      = out_mon.point_x;
                got.y      = out_mon.point_y;
                got.idx    = out_mon.multiple_index;
                got.last   = out_mon.last_point;
                got.status = out_mon.run_status;
                if (due_wr == due_rd) begin
                    if (o_fail_count < 10)
                        $display("unexpected point x=%0d y=%0d k=%0d", got.x, got.y, got.idx);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = points_due[due_rd % DEPTH];
                    due_rd = due_rd + 1;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch exp x=%0d y=%0d k=%0d last=%0d st=%0d",
                                " act x=%0d y=%0d k=%0d last=%0d st=%0d"},
                                want.x, want.y, want.idx, want.last, want.status,
                                got.x, got.y, got.idx, got.last, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_points_due <= due_wr - due_rd;
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the subgroup generator
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int LIMIT       = 30_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel, penable, pwrite;
    logic [ecsg_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    int                             fail_count;
    int                             points_due;
    int                             send_idle;
    int                             recv_idle;
    int                             hold_ask;
    int                             hold_seen = 0;
    int                             hold_left = 0;
    int                             cycles = 0;

    ecsg_in_if  in_if ();
    ecsg_out_if out_if ();

    elliptic_curve_subgroup_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ecsg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_if),
        .out_mon      (out_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_points_due (points_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[elliptic_curve_subgroup_generator] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic [ecsg_pkg::ADDR_BITS-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_gen(ecsg_pkg::t_elem x, ecsg_pkg::t_elem y);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.gen_x <= x;
        in_if.gen_y <= y;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (points_due != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_curve(int p, int a);
        drain();
        write_reg(ecsg_pkg::ADDR_PRIME, p);
        write_reg(ecsg_pkg::ADDR_COEFF, a);
    endtask

    function automatic ecsg_pkg::t_elem rand_coord(int p);
        if ($urandom_range(3) == 0) return ecsg_pkg::t_elem'($urandom_range(16'hFFFF));
        return ecsg_pkg::t_elem'($urandom_range(p - 1));
    endfunction

    int primes[14] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

    initial begin
        int p, a;
        ecsg_pkg::t_elem y;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_if.valid = 1'b0;
        in_if.gen_x = '0;
        in_if.gen_y = '0;
        send_idle   = 0;
        recv_idle   = 0;
        hold_ask    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gen(16'd5, 16'd1);
        send_gen(16'd3, 16'd0);
        send_gen(16'd0, 16'd0);
        send_gen(16'hFFFF, 16'hFFFF);
        send_gen(16'd18, 16'd18);
        send_gen(16'd38, 16'd20);
        set_curve(0, 0);
        send_gen(16'd1, 16'd1);
        send_gen(16'd2, 16'd2);
        set_curve(2, 16'hFFFF);
        send_gen(16'd0, 16'd1);
        set_curve(1, 1);
        send_gen(16'd1, 16'd2);
        set_curve(15, 7);
        send_gen(16'd4, 16'd3);
        send_gen(16'd2, 16'd9);
        set_curve(3, 0);
        send_gen(16'd0, 16'd1);
        send_gen(16'd2, 16'd2);
        set_curve(65521, 65520);
        send_gen(16'd3, 16'd7);
        send_gen(16'hFFF0, 16'd0);
        set_curve(65535, 16'hAAAA);
        send_gen(16'h5555, 16'h1234);
        set_curve(16'h8000, 16'h5555);
        send_gen(16'd9, 16'd4);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
            recv_idle = (phase == 0) ? 54 : (phase == 1) ? 37 : 0;
            for (int batch = 0; batch < 4; batch++) begin
                p = primes[$urandom_range(13)];
                a = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(p - 1);
                set_curve(p, a);
                if (phase == 2 && batch == 0) hold_ask = hold_ask + 1;
                for (int n = 0; n < 10; n++) begin
                    y = ($urandom_range(9) == 0) ? 16'd0 : rand_coord(p);
                    send_gen(rand_coord(p), y);
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("[elliptic_curve_subgroup_generator] OK");
        end else begin
            $display("[elliptic_curve_subgroup_generator] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ecsg_pkg.sv
hw/rtl/ecsg_if.sv
hw/rtl/ecsg_modmul.sv
hw/rtl/ecsg_seq.sv
hw/rtl/elliptic_curve_subgroup_generator.sv
bench/ecsg_checker.sv
bench/tb.sv
